// File: rtl/gsdd_pkg.sv
// ----------------------------------------------------------------------------
// gsdd_pkg
// Shared types and constants of the gyro swing direction detector.
// ----------------------------------------------------------------------------
package gsdd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DIR_W = 3;
	localparam int IN_DATA_W = 2 * SAMPLE_W;
	localparam int OUT_DATA_W = 8;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_NONE  = 3'd0,
		DIR_UP    = 3'd1,
		DIR_DOWN  = 3'd2,
		DIR_LEFT  = 3'd3,
		DIR_RIGHT = 3'd4
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UP_LIMIT    = 2'd0,
		REG_DOWN_LIMIT  = 2'd1,
		REG_LEFT_LIMIT  = 2'd2,
		REG_RIGHT_LIMIT = 2'd3
	} cfg_reg_t;

	localparam sample_t UP_LIMIT_RST    = 16'sd200;
	localparam sample_t DOWN_LIMIT_RST  = -16'sd250;
	localparam sample_t LEFT_LIMIT_RST  = 16'sd100;
	localparam sample_t RIGHT_LIMIT_RST = -16'sd120;

	// control of one detector: shift its window, and whether it seeks a peak
	typedef struct packed {
		logic shift;
		logic peak;
	} det_ctrl_t;

endpackage

// File: rtl/gsdd_detector.sv
// ----------------------------------------------------------------------------
// gsdd_detector
// Two-sample window and strict extremum test against a limit.
// ----------------------------------------------------------------------------
module gsdd_detector (
	input  logic               clk,
	input  logic               arst_n,
	input  gsdd_pkg::det_ctrl_t ctrl,
	input  gsdd_pkg::sample_t  sample,
	input  gsdd_pkg::sample_t  limit,
	output logic               fire
);
	import gsdd_pkg::*;

	sample_t newest_q;
	sample_t older_q;
	logic    is_max;
	logic    is_min;

	// middle sample is the newest stored one
	assign is_max = (newest_q > sample) && (newest_q > older_q);
	assign is_min = (newest_q < sample) && (newest_q < older_q);
	assign fire = ctrl.peak ? (is_max && (newest_q > limit))
	                        : (is_min && (newest_q < limit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			older_q  <= '0;
		end else if (ctrl.shift) begin
			older_q  <= newest_q;
			newest_q <= sample;
		end
	end

endmodule

// File: rtl/gyro_swing_direction_detector_top.sv
// ----------------------------------------------------------------------------
// gyro_swing_direction_detector_top
// Classifies gyro swings as up, down, left or right from rate peaks.
// ----------------------------------------------------------------------------
// Each input transaction is registered in stage s1 and, in the cycle it
// leaves s1, is evaluated by four window detectors (up and down on rate_x,
// left and right on rate_z) whose verdict is written into the output
// register. The result is presented on the output once the item moves from
// s1 into the output register, which a stalled output can hold back. One
// transaction is taken every cycle as long as the output side keeps up,
// since s1 hands its item on in the same cycle that it takes the next one;
// a stalled output holds s1, and s1 then holds the input.
// A gyro item (tuser high) updates the held direction, none included; any
// other item returns the held direction unchanged. Limits are written through
// the cfg channel, which is always ready, and should only be changed while
// the block is idle.
module gyro_swing_direction_detector_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gsdd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gsdd_pkg::SAMPLE_W-1:0]   cfg_data,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [gsdd_pkg::IN_DATA_W-1:0]  s_tdata,   // rate_x [15:0], rate_z [31:16]
	input  logic                            s_tuser,   // func
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gsdd_pkg::OUT_DATA_W-1:0] m_tdata    // direction [2:0], zeros above
);
	import gsdd_pkg::*;

	// limit registers
	sample_t up_limit_q;
	sample_t down_limit_q;
	sample_t left_limit_q;
	sample_t right_limit_q;

	// input stage
	logic    valid_s1;
	logic    func_s1;
	sample_t rate_x_s1;
	sample_t rate_z_s1;

	// result register
	logic    out_valid_q;
	dir_t    held_q;

	logic      advance;
	logic      gyro_go;
	logic      fire_up, fire_down, fire_left, fire_right;
	det_ctrl_t ctrl_up, ctrl_down, ctrl_left, ctrl_right;
	dir_t      dir_found;

	// ---- configuration: always accept, drop nothing ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_limit_q    <= UP_LIMIT_RST;
			down_limit_q  <= DOWN_LIMIT_RST;
			left_limit_q  <= LEFT_LIMIT_RST;
			right_limit_q <= RIGHT_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_UP_LIMIT:    up_limit_q    <= sample_t'(cfg_data);
				REG_DOWN_LIMIT:  down_limit_q  <= sample_t'(cfg_data);
				REG_LEFT_LIMIT:  left_limit_q  <= sample_t'(cfg_data);
				REG_RIGHT_LIMIT: right_limit_q <= sample_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// ---- flow control ----
	// s1 moves on whenever the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign gyro_go  = advance && func_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload of s1 needs no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1   <= s_tuser;
			rate_x_s1 <= sample_t'(s_tdata[SAMPLE_W-1:0]);
			rate_z_s1 <= sample_t'(s_tdata[IN_DATA_W-1:SAMPLE_W]);
		end
	end

	// ---- detectors: a later one shifts only if none before it fired ----
	assign ctrl_up    = '{shift: gyro_go, peak: 1'b1};
	assign ctrl_down  = '{shift: gyro_go && !fire_up, peak: 1'b0};
	assign ctrl_left  = '{shift: gyro_go && !fire_up && !fire_down, peak: 1'b1};
	assign ctrl_right = '{shift: gyro_go && !fire_up && !fire_down && !fire_left,
	                      peak: 1'b0};

	gsdd_detector u_up (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_up),
		.sample(rate_x_s1), .limit(up_limit_q), .fire(fire_up)
	);
	gsdd_detector u_down (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_down),
		.sample(rate_x_s1), .limit(down_limit_q), .fire(fire_down)
	);
	gsdd_detector u_left (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_left),
		.sample(rate_z_s1), .limit(left_limit_q), .fire(fire_left)
	);
	gsdd_detector u_right (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_right),
		.sample(rate_z_s1), .limit(right_limit_q), .fire(fire_right)
	);

	// priority: up, down, left, right
	always_comb begin
		if (fire_up)
			dir_found = DIR_UP;
		else if (fire_down)
			dir_found = DIR_DOWN;
		else if (fire_left)
			dir_found = DIR_LEFT;
		else if (fire_right)
			dir_found = DIR_RIGHT;
		else
			dir_found = DIR_NONE;
	end

	// ---- result register; the held direction doubles as the output ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_q      <= DIR_NONE;
		end else begin
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			if (gyro_go)
				held_q <= dir_found;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-DIR_W){1'b0}}, held_q};

	// ---- assertions ----
	// a stalled result keeps its direction
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// a non-gyro item leaves the held direction alone
	a_non_gyro: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !func_s1 |=> $stable(held_q))
		else $error("held direction moved on a non-gyro item");

	// an item in s1 is never lost under back-pressure
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |=> valid_s1 && $stable(rate_x_s1))
		else $error("input stage dropped a stalled item");

	// a presented direction code is always one of the five defined ones
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= OUT_DATA_W'(DIR_RIGHT))
		else $error("direction code out of range");

endmodule
